// File: sv/ppsv_pkg.sv
`default_nettype none
package ppsv_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int COORD_W     = 24;
    localparam int RADIUS_W    = 16;
    localparam int SW_W        = 15;
    localparam int FRAC_W      = FRAC_BITS + 1;
    localparam int DIFF_W      = COORD_W + 1;
    localparam int D2_W        = 2 * DIFF_W;
    localparam int ROOT_W      = DIFF_W;
    localparam int DR_W        = 16;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [FRAC_W-1:0] ONE      = FRAC_W'(1) << FRAC_BITS;
    localparam logic [SW_W-1:0]   SW_RESET = SW_W'(1966);
    localparam logic [15:0]       K952     = 16'd62390;
    localparam logic [16:0]       C03      = 17'((3 * (1 << FRAC_BITS) + 50) / 100);

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_BURY,
        KIND_SWITCH
    } kind_t;

    typedef struct packed {
        kind_t                  kind;
        logic signed [DR_W-1:0] dr;
        logic [SW_W-1:0]        sw;
        logic                   last;
    } atom_item_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_SQX,
        F_SQY,
        F_SQZ,
        F_ROOT,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_DIV,
        B_SQ,
        B_CUBE,
        B_U,
        B_PROD,
        B_FIN
    } back_state_t;

endpackage
`default_nettype wire

// File: sv/probe_point_smoothed_volume_core.sv
// Channel   | Handshake        | Payload
// atoms in  | push / full      | probe_x/y/z, atom_x/y/z, atom_radius, last_atom
// result    | empty / pop      | volume_fraction, fully_buried
// config    | switch_half_width_we | switch_half_width
//
// Front: accept, square x, y and z, bit-serial square root, then push (held while the queue is full).
// Back: idle then finish outside the switching band; inside, a 16-step divider and three multiplies come between.
// Throughput is set by the front's bit-serial square root; the queue absorbs back stalls.
// Reset clears control, the running product (one) and the buried flag; no clearing pass.
// A waiting result stalls the back on a last atom; the front keeps accepting until the queue fills.
`default_nettype none
module probe_point_smoothed_volume_core #(
    parameter int QUEUE_DEPTH = ppsv_pkg::QUEUE_DEPTH
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 switch_half_width_we,
    input  wire logic [ppsv_pkg::SW_W-1:0]            switch_half_width,
    input  wire logic                                 push,
    output logic                                      full,
    input  wire logic signed [ppsv_pkg::COORD_W-1:0]  probe_x,
    input  wire logic signed [ppsv_pkg::COORD_W-1:0]  probe_y,
    input  wire logic signed [ppsv_pkg::COORD_W-1:0]  probe_z,
    input  wire logic signed [ppsv_pkg::COORD_W-1:0]  atom_x,
    input  wire logic signed [ppsv_pkg::COORD_W-1:0]  atom_y,
    input  wire logic signed [ppsv_pkg::COORD_W-1:0]  atom_z,
    input  wire logic [ppsv_pkg::RADIUS_W-1:0]        atom_radius,
    input  wire logic                                 last_atom,
    output logic                                      empty,
    input  wire logic                                 pop,
    output logic [ppsv_pkg::FRAC_W-1:0]               volume_fraction,
    output logic                                      fully_buried
);
    import ppsv_pkg::*;

    logic [SW_W-1:0] sw_reg;
    logic            q_push, q_full, q_pop, q_empty;
    atom_item_t      q_wr_item, q_rd_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sw_reg <= SW_RESET;
        else if (switch_half_width_we)
            sw_reg <= switch_half_width;
    end

    ppsv_front u_front (
        .clk, .rst_n, .push, .full,
        .probe_x, .probe_y, .probe_z, .atom_x, .atom_y, .atom_z,
        .atom_radius, .last_atom,
        .sw(sw_reg), .q_push, .q_item(q_wr_item), .q_full
    );

    ppsv_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk, .rst_n, .wr_en(q_push), .wr_item(q_wr_item), .q_full,
        .rd_en(q_pop), .rd_item(q_rd_item), .q_empty
    );

    ppsv_back u_back (
        .clk, .rst_n, .q_empty, .q_item(q_rd_item), .q_pop,
        .empty, .pop, .volume_fraction, .fully_buried
    );

endmodule
`default_nettype wire

// File: sv/ppsv_front.sv
`default_nettype none
module ppsv_front (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 push,
    output logic                                      full,
    input  wire logic signed [ppsv_pkg::COORD_W-1:0]  probe_x,
    input  wire logic signed [ppsv_pkg::COORD_W-1:0]  probe_y,
    input  wire logic signed [ppsv_pkg::COORD_W-1:0]  probe_z,
    input  wire logic signed [ppsv_pkg::COORD_W-1:0]  atom_x,
    input  wire logic signed [ppsv_pkg::COORD_W-1:0]  atom_y,
    input  wire logic signed [ppsv_pkg::COORD_W-1:0]  atom_z,
    input  wire logic [ppsv_pkg::RADIUS_W-1:0]        atom_radius,
    input  wire logic                                 last_atom,
    input  wire logic [ppsv_pkg::SW_W-1:0]            sw,
    output logic                                      q_push,
    output ppsv_pkg::atom_item_t                      q_item,
    input  wire logic                                 q_full
);
    import ppsv_pkg::*;

    front_state_t state_reg, state_next;
    logic signed [DIFF_W-1:0] dx_reg, dy_reg, dz_reg;
    logic [RADIUS_W-1:0]      r_reg;
    logic                     last_reg;
    logic [SW_W-1:0]          sw_reg;
    logic [D2_W-1:0]          acc_reg, acc_next;
    logic [16:0]              reff_reg;
    logic [D2_W-1:0]          rad_reg, rad_next;
    logic [ROOT_W+1:0]        rem_reg, rem_next;
    logic [ROOT_W-1:0]        root_reg, root_next;
    logic [4:0]               cnt_reg, cnt_next;

    logic signed [DIFF_W-1:0]   sq_op;
    logic signed [D2_W-1:0]     sq_prod;
    logic [32:0]                reff_prod;
    logic [ROOT_W+1:0]          rem_sh, trial;
    logic signed [ROOT_W+1:0]   diff, sw_s;
    logic                       accept;

    assign accept    = push && !full;
    assign sq_prod   = sq_op * sq_op;
    assign reff_prod = 33'({1'b0, r_reg} + C03) * 33'(K952) + 33'd32768;
    assign rem_sh    = {rem_reg[ROOT_W-1:0], rad_reg[D2_W-1 -: 2]};
    assign trial     = {root_reg, 2'b01};
    assign diff      = $signed({2'b00, root_reg}) - $signed((ROOT_W+2)'(reff_reg));
    assign sw_s      = $signed((ROOT_W+2)'(sw_reg));

    always_comb
    begin
        case (state_reg)
            F_SQX:   sq_op = dx_reg;
            F_SQY:   sq_op = dy_reg;
            default: sq_op = dz_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            dx_reg   <= DIFF_W'(probe_x) - DIFF_W'(atom_x);
            dy_reg   <= DIFF_W'(probe_y) - DIFF_W'(atom_y);
            dz_reg   <= DIFF_W'(probe_z) - DIFF_W'(atom_z);
            r_reg    <= atom_radius;
            last_reg <= last_atom;
            sw_reg   <= (sw == '0) ? SW_W'(1) : sw;
        end
        if (state_reg == F_SQX)
        begin
            reff_reg <= reff_prod[32:16];
        end
        acc_reg  <= acc_next;
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        cnt_reg  <= cnt_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        acc_next    = acc_reg;
        rad_next    = rad_reg;
        rem_next    = rem_reg;
        root_next   = root_reg;
        cnt_next    = cnt_reg;
        full        = 1'b1;
        q_push      = 1'b0;
        q_item.kind = KIND_NONE;
        q_item.dr   = DR_W'(diff);
        q_item.sw   = sw_reg;
        q_item.last = last_reg;
        if (diff + sw_s <= 0)
            q_item.kind = KIND_BURY;
        else if (diff < sw_s)
            q_item.kind = KIND_SWITCH;
        case (state_reg)
            F_IDLE:
            begin
                full = 1'b0;
                if (push)
                    state_next = F_SQX;
            end
            F_SQX:
            begin
                acc_next   = D2_W'(sq_prod);
                state_next = F_SQY;
            end
            F_SQY:
            begin
                acc_next   = acc_reg + D2_W'(sq_prod);
                state_next = F_SQZ;
            end
            F_SQZ:
            begin
                rad_next   = acc_reg + D2_W'(sq_prod);
                rem_next   = '0;
                root_next  = '0;
                cnt_next   = '0;
                state_next = F_ROOT;
            end
            F_ROOT:
            begin
                rad_next = rad_reg << 2;
                if (rem_sh >= trial)
                begin
                    rem_next  = rem_sh - trial;
                    root_next = {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_sh;
                    root_next = {root_reg[ROOT_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(ROOT_W - 1))
                    state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (!q_full)
                begin
                    q_push     = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

endmodule
`default_nettype wire

// File: sv/ppsv_queue.sv
`default_nettype none
module ppsv_queue #(
    parameter int DEPTH = ppsv_pkg::QUEUE_DEPTH
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 wr_en,
    input  wire ppsv_pkg::atom_item_t wr_item,
    output logic                      q_full,
    input  wire logic                 rd_en,
    output ppsv_pkg::atom_item_t      rd_item,
    output logic                      q_empty
);
    import ppsv_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    atom_item_t      mem_reg [DEPTH];
    logic [PW-1:0]   wp_reg, rp_reg;
    logic [CW-1:0]   cnt_reg;

    assign q_full  = (cnt_reg == CW'(DEPTH));
    assign q_empty = (cnt_reg == '0);
    assign rd_item = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wp_reg] <= wr_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en)
                wp_reg <= (wp_reg == PW'(DEPTH - 1)) ? '0 : wp_reg + PW'(1);
            if (rd_en)
                rp_reg <= (rp_reg == PW'(DEPTH - 1)) ? '0 : rp_reg + PW'(1);
            if (wr_en && !rd_en)
                cnt_reg <= cnt_reg + CW'(1);
            else if (rd_en && !wr_en)
                cnt_reg <= cnt_reg - CW'(1);
        end
    end

endmodule
`default_nettype wire

// File: sv/ppsv_back.sv
`default_nettype none
module ppsv_back (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        q_empty,
    input  wire ppsv_pkg::atom_item_t        q_item,
    output logic                             q_pop,
    output logic                             empty,
    input  wire logic                        pop,
    output logic [ppsv_pkg::FRAC_W-1:0]      volume_fraction,
    output logic                             fully_buried
);
    import ppsv_pkg::*;

    back_state_t     state_reg, state_next;
    atom_item_t      item_reg;
    logic [FRAC_W-1:0] prod_reg, prod_next;
    logic            buried_reg, buried_next;
    logic [15:0]     rem_reg, rem_next;
    logic [15:0]     q_reg, q_next;
    logic [3:0]      cnt_reg, cnt_next;
    logic [15:0]     t2_reg, m3_reg;
    logic [FRAC_W-1:0] u_reg;
    logic            out_valid_reg;
    logic [FRAC_W-1:0] out_vol_reg;
    logic            out_bur_reg;

    logic [16:0]         rem_sh;
    logic [31:0]         sq32, cu32;
    logic signed [19:0]  t_s, num;
    logic [FRAC_W-1:0]   u_calc;
    logic [2*FRAC_W-1:0] pmul;
    logic [FRAC_W:0]     pr;
    logic                load_out;

    assign rem_sh = {rem_reg, 1'b0};
    assign sq32   = q_reg * q_reg;
    assign cu32   = t2_reg * q_reg;
    assign t_s    = item_reg.dr[DR_W-1] ? -$signed({4'b0, q_reg}) : $signed({4'b0, q_reg});
    assign num    = 20'sd131072 + 20'sd3 * t_s
                    - (item_reg.dr[DR_W-1] ? -$signed({4'b0, m3_reg}) : $signed({4'b0, m3_reg}));
    assign pmul   = prod_reg * u_reg;
    assign pr     = (FRAC_W+1)'((pmul + (2*FRAC_W)'(32768)) >> FRAC_BITS);

    always_comb
    begin
        if (num < 0)
            u_calc = '0;
        else if ((num >>> 2) > $signed({3'b0, ONE}))
            u_calc = ONE;
        else
            u_calc = FRAC_W'(num >>> 2);
    end

    assign empty           = !out_valid_reg;
    assign volume_fraction = out_vol_reg;
    assign fully_buried    = out_bur_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            prod_reg      <= ONE;
            buried_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            prod_reg   <= prod_next;
            buried_reg <= buried_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            item_reg <= q_item;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        cnt_reg <= cnt_next;
        if (state_reg == B_SQ)
            t2_reg <= sq32[31:16];
        if (state_reg == B_CUBE)
            m3_reg <= cu32[31:16];
        if (state_reg == B_U)
            u_reg <= u_calc;
        if (load_out)
        begin
            out_vol_reg <= prod_reg;
            out_bur_reg <= buried_reg;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        prod_next   = prod_reg;
        buried_next = buried_reg;
        rem_next    = rem_reg;
        q_next      = q_reg;
        cnt_next    = cnt_reg;
        q_pop       = 1'b0;
        load_out    = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    case (q_item.kind)
                        KIND_BURY:
                        begin
                            prod_next   = '0;
                            buried_next = 1'b1;
                            state_next  = B_FIN;
                        end
                        KIND_SWITCH:
                        begin
                            rem_next   = q_item.dr[DR_W-1] ? 16'(-q_item.dr) : 16'(q_item.dr);
                            q_next     = '0;
                            cnt_next   = '0;
                            state_next = B_DIV;
                        end
                        default: state_next = B_FIN;
                    endcase
                end
            end
            B_DIV:
            begin
                if (rem_sh >= 17'(item_reg.sw))
                begin
                    rem_next = 16'(rem_sh - 17'(item_reg.sw));
                    q_next   = {q_reg[14:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh[15:0];
                    q_next   = {q_reg[14:0], 1'b0};
                end
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                    state_next = B_SQ;
            end
            B_SQ:   state_next = B_CUBE;
            B_CUBE: state_next = B_U;
            B_U:    state_next = B_PROD;
            B_PROD:
            begin
                prod_next  = (pr > (FRAC_W+1)'(ONE)) ? ONE : FRAC_W'(pr);
                state_next = B_FIN;
            end
            B_FIN:
            begin
                if (!item_reg.last)
                    state_next = B_IDLE;
                else if (!out_valid_reg)
                begin
                    load_out    = 1'b1;
                    prod_next   = ONE;
                    buried_next = 1'b0;
                    state_next  = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    a_prod_range: assert property (@(posedge clk) disable iff (!rst_n)
        prod_reg <= ONE) else $error("running product above one");
    a_buried_zero: assert property (@(posedge clk) disable iff (!rst_n)
        buried_reg |-> prod_reg == '0) else $error("buried with nonzero product");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !pop |=> out_valid_reg && $stable(out_vol_reg))
        else $error("result lost before pop");
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> !out_valid_reg) else $error("result overwritten");

endmodule
`default_nettype wire
